### src/oad_pkg.sv
package oad_pkg;

   // Fixed field widths.
   localparam int KIND_WIDTH      = 2;
   localparam int MOTION_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int TIMER_WIDTH     = 16;
   localparam int FAR_BITS        = 14;

   // Item kinds.
   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_TICK  = 2'd0,
      KIND_FORCE = 2'd1,
      KIND_MODE  = 2'd2,
      KIND_ESTOP = 2'd3
   } kind_type;

   // Motion states.
   typedef enum logic [MOTION_WIDTH-1:0] {
      MOTION_STOP  = 3'd0,
      MOTION_FWD   = 3'd1,
      MOTION_BACK  = 3'd2,
      MOTION_LEFT  = 3'd3,
      MOTION_RIGHT = 3'd4
   } motion_type;

   // Drive modes.
   localparam logic MODE_AUTO   = 1'b0;
   localparam logic MODE_REMOTE = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_LIMIT     = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIDE_LIMIT     = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BACKWARD_TICKS = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TURN_DWELL     = 8'd3;

   // Register reset values.
   localparam logic [CSR_DATA_WIDTH-1:0] STOP_LIMIT_RESET     = 16'd30;
   localparam logic [CSR_DATA_WIDTH-1:0] SIDE_LIMIT_RESET     = 16'd15;
   localparam logic [CSR_DATA_WIDTH-1:0] BACKWARD_TICKS_RESET = 16'd10;
   localparam logic [CSR_DATA_WIDTH-1:0] TURN_DWELL_RESET     = 16'd10;

   // Far distance assumed for a missing echo, and the stop dwell.
   localparam logic [FAR_BITS-1:0]    NO_ECHO_FAR = 14'd9999;
   localparam logic [TIMER_WIDTH-1:0] STOP_DWELL  = 16'd2;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX   = 16'hFFFF;

   // Configuration register file contents.
   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] stop_limit;
      logic [CSR_DATA_WIDTH-1:0] side_limit;
      logic [CSR_DATA_WIDTH-1:0] backward_ticks;
      logic [CSR_DATA_WIDTH-1:0] turn_dwell;
   } cfg_type;

   // Obstacle flags of one tick.
   typedef struct packed {
      logic front;
      logic rear;
      logic left;
      logic right;
      logic right_farther;
   } sense_type;

   // One result item.
   typedef struct packed {
      motion_type motion;
      logic       mode_now;
      logic       front_hit;
      logic       rear_hit;
      logic       left_hit;
      logic       right_hit;
   } rsp_type;

endpackage

### src/oad_req_if.sv
interface oad_req_if #(
   parameter int DIST_WIDTH = 16
);
   logic                              valid;
   logic                              ready;
   logic [oad_pkg::KIND_WIDTH-1:0]    kind;
   logic [DIST_WIDTH-1:0]             dist_front_left;
   logic [DIST_WIDTH-1:0]             dist_front_right;
   logic [DIST_WIDTH-1:0]             dist_back_left;
   logic [DIST_WIDTH-1:0]             dist_back_right;
   logic [oad_pkg::MOTION_WIDTH-1:0]  forced_state;
   logic                              wanted_mode;

   modport source (
      output valid, kind, dist_front_left, dist_front_right, dist_back_left,
             dist_back_right, forced_state, wanted_mode,
      input  ready
   );
   modport sink (
      input  valid, kind, dist_front_left, dist_front_right, dist_back_left,
             dist_back_right, forced_state, wanted_mode,
      output ready
   );
endinterface

### src/oad_rsp_if.sv
interface oad_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [oad_pkg::MOTION_WIDTH-1:0]  motion;
   logic                              mode_now;
   logic                              front_hit;
   logic                              rear_hit;
   logic                              left_hit;
   logic                              right_hit;

   modport source (
      output valid, motion, mode_now, front_hit, rear_hit, left_hit, right_hit,
      input  ready
   );
   modport sink (
      input  valid, motion, mode_now, front_hit, rear_hit, left_hit, right_hit,
      output ready
   );
endinterface

### src/oad_csr_if.sv
interface oad_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [oad_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [oad_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

### src/oad_csr.sv
module oad_csr (
   input  logic             clock,
   input  logic             reset,
   oad_csr_if.sink          csr_chan,
   output oad_pkg::cfg_type cfg
);

   oad_pkg::cfg_type cfg_ff;
   oad_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_chan.ready = 1'b1;

   // Decode the register index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            oad_pkg::CSR_STOP_LIMIT:     cfg_in.stop_limit     = csr_chan.data;
            oad_pkg::CSR_SIDE_LIMIT:     cfg_in.side_limit     = csr_chan.data;
            oad_pkg::CSR_BACKWARD_TICKS: cfg_in.backward_ticks = csr_chan.data;
            oad_pkg::CSR_TURN_DWELL:     cfg_in.turn_dwell     = csr_chan.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_limit     <= oad_pkg::STOP_LIMIT_RESET;
         cfg_ff.side_limit     <= oad_pkg::SIDE_LIMIT_RESET;
         cfg_ff.backward_ticks <= oad_pkg::BACKWARD_TICKS_RESET;
         cfg_ff.turn_dwell     <= oad_pkg::TURN_DWELL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/oad_sense.sv
module oad_sense #(
   parameter int DIST_WIDTH = 16
) (
   input  logic [DIST_WIDTH-1:0]  dist_front_left,
   input  logic [DIST_WIDTH-1:0]  dist_front_right,
   input  logic [DIST_WIDTH-1:0]  dist_back_left,
   input  logic [DIST_WIDTH-1:0]  dist_back_right,
   input  oad_pkg::cfg_type       cfg,
   output oad_pkg::sense_type     sense
);

   // Compare widths cover both the readings and the thresholds or far value.
   localparam int CMP_WIDTH =
      (DIST_WIDTH > oad_pkg::CSR_DATA_WIDTH) ? DIST_WIDTH : oad_pkg::CSR_DATA_WIDTH;
   localparam int FAR_WIDTH =
      (DIST_WIDTH > oad_pkg::FAR_BITS) ? DIST_WIDTH : oad_pkg::FAR_BITS;

   logic [CMP_WIDTH-1:0] fl_c, fr_c, bl_c, br_c;
   logic [CMP_WIDTH-1:0] stop_c, danger_c;
   logic [FAR_WIDTH-1:0] fl_far, fr_far, bl_far, br_far;
   logic [FAR_WIDTH-1:0] left_far, right_far;
   logic                 fl_echo, fr_echo, bl_echo, br_echo;

   assign fl_echo = (dist_front_left  != '0);
   assign fr_echo = (dist_front_right != '0);
   assign bl_echo = (dist_back_left   != '0);
   assign br_echo = (dist_back_right  != '0);

   assign fl_c     = CMP_WIDTH'(dist_front_left);
   assign fr_c     = CMP_WIDTH'(dist_front_right);
   assign bl_c     = CMP_WIDTH'(dist_back_left);
   assign br_c     = CMP_WIDTH'(dist_back_right);
   assign stop_c   = CMP_WIDTH'(cfg.stop_limit);
   assign danger_c = CMP_WIDTH'(cfg.side_limit);

   // A reading blocks only when an echo came back closer than the threshold.
   assign sense.front = (fl_echo && (fl_c < stop_c)) || (fr_echo && (fr_c < stop_c));
   assign sense.rear  = (bl_echo && (bl_c < stop_c)) || (br_echo && (br_c < stop_c));
   assign sense.left  = (fl_echo && (fl_c < danger_c)) || (bl_echo && (bl_c < danger_c));
   assign sense.right = (fr_echo && (fr_c < danger_c)) || (br_echo && (br_c < danger_c));

   // Far distance per side; a missing echo counts as open space.
   assign fl_far = fl_echo ? FAR_WIDTH'(dist_front_left)  : FAR_WIDTH'(oad_pkg::NO_ECHO_FAR);
   assign fr_far = fr_echo ? FAR_WIDTH'(dist_front_right) : FAR_WIDTH'(oad_pkg::NO_ECHO_FAR);
   assign bl_far = bl_echo ? FAR_WIDTH'(dist_back_left)   : FAR_WIDTH'(oad_pkg::NO_ECHO_FAR);
   assign br_far = br_echo ? FAR_WIDTH'(dist_back_right)  : FAR_WIDTH'(oad_pkg::NO_ECHO_FAR);

   assign left_far  = (fl_far > bl_far) ? fl_far : bl_far;
   assign right_far = (fr_far > br_far) ? fr_far : br_far;

   assign sense.right_farther = (right_far > left_far);

endmodule

### src/oad_fsm.sv
module oad_fsm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [oad_pkg::KIND_WIDTH-1:0]    kind,
   input  logic [oad_pkg::MOTION_WIDTH-1:0]  forced_state,
   input  logic                              wanted_mode,
   input  oad_pkg::sense_type                sense,
   input  oad_pkg::cfg_type                  cfg,
   output oad_pkg::rsp_type                  result
);

   oad_pkg::motion_type                  motion_ff, motion_in;
   logic                                 mode_ff, mode_in;
   logic [oad_pkg::TIMER_WIDTH-1:0]      dwell_ff, dwell_in;
   logic [oad_pkg::TIMER_WIDTH-1:0]      dwell_inc;
   logic                                 auto_tick;
   oad_pkg::rsp_type                     result_ff, result_in;

   // Saturating dwell timer increment.
   assign dwell_inc = (dwell_ff == oad_pkg::TIMER_MAX) ? dwell_ff : dwell_ff + 1'b1;

   assign auto_tick = (oad_pkg::kind_type'(kind) == oad_pkg::KIND_TICK) &&
                      (mode_ff == oad_pkg::MODE_AUTO);

   // Next state of the drive machine for the item in the input register.
   always_comb begin
      motion_in = motion_ff;
      mode_in   = mode_ff;
      dwell_in  = dwell_ff;
      case (oad_pkg::kind_type'(kind))
         oad_pkg::KIND_TICK: begin
            if (auto_tick) begin
               case (motion_ff)
                  oad_pkg::MOTION_FWD: begin
                     if (sense.front) begin
                        motion_in = oad_pkg::MOTION_STOP;
                        dwell_in  = '0;
                     end
                  end
                  oad_pkg::MOTION_STOP: begin
                     dwell_in = dwell_inc;
                     if (dwell_inc > oad_pkg::STOP_DWELL) begin
                        if (sense.front && !sense.rear) begin
                           motion_in = oad_pkg::MOTION_BACK;
                           dwell_in  = '0;
                        end else if (!sense.front) begin
                           motion_in = oad_pkg::MOTION_FWD;
                           dwell_in  = '0;
                        end
                     end
                  end
                  oad_pkg::MOTION_BACK: begin
                     dwell_in = dwell_inc;
                     if (dwell_inc > cfg.backward_ticks) begin
                        if (sense.right_farther && !sense.right) begin
                           motion_in = oad_pkg::MOTION_RIGHT;
                        end else if (!sense.left) begin
                           motion_in = oad_pkg::MOTION_LEFT;
                        end else if (!sense.front) begin
                           motion_in = oad_pkg::MOTION_FWD;
                        end else begin
                           motion_in = oad_pkg::MOTION_STOP;
                        end
                        dwell_in = '0;
                     end
                     // A blocked rear always wins while reversing.
                     if (sense.rear) begin
                        motion_in = oad_pkg::MOTION_STOP;
                        dwell_in  = '0;
                     end
                  end
                  oad_pkg::MOTION_LEFT, oad_pkg::MOTION_RIGHT: begin
                     dwell_in = dwell_inc;
                     if (dwell_inc > cfg.turn_dwell) begin
                        motion_in = sense.front ? oad_pkg::MOTION_STOP
                                                : oad_pkg::MOTION_FWD;
                        dwell_in  = '0;
                     end
                  end
                  default: motion_in = oad_pkg::MOTION_STOP;
               endcase
            end
         end
         oad_pkg::KIND_FORCE: begin
            if (forced_state inside {[oad_pkg::MOTION_STOP:oad_pkg::MOTION_RIGHT]}) begin
               motion_in = oad_pkg::motion_type'(forced_state);
            end else begin
               motion_in = oad_pkg::MOTION_STOP;
            end
            dwell_in = '0;
         end
         oad_pkg::KIND_MODE: begin
            if (wanted_mode != mode_ff) begin
               mode_in   = wanted_mode;
               motion_in = oad_pkg::MOTION_STOP;
               dwell_in  = '0;
            end
         end
         default: motion_in = oad_pkg::MOTION_STOP;
      endcase
   end

   // Result reflects the state after the update.
   always_comb begin
      result_in.motion    = motion_in;
      result_in.mode_now  = mode_in;
      result_in.front_hit = auto_tick && sense.front;
      result_in.rear_hit  = auto_tick && sense.rear;
      result_in.left_hit  = auto_tick && sense.left;
      result_in.right_hit = auto_tick && sense.right;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff <= oad_pkg::MOTION_STOP;
         mode_ff   <= oad_pkg::MODE_AUTO;
         dwell_ff  <= '0;
      end else if (step) begin
         motion_ff <= motion_in;
         mode_ff   <= mode_in;
         dwell_ff  <= dwell_in;
      end
   end

   // Result register, payload only.
   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### src/obstacle_avoid_drive_fsm.sv
// Channel    Dir  Handshake    Carries
// req_chan   in   valid/ready  kind, four distance readings, forced_state, wanted_mode
// rsp_chan   out  valid/ready  motion, mode_now, four obstacle flags
// csr_chan   in   valid/ready  register index and 16-bit write data
//
// One item per cycle sustained while rsp_chan.ready stays high; each result passes
// through the input register, then the result register, before it is offered.
// The state update is combinational through the sense compares and the drive
// machine next-state logic.
// Reset is synchronous and active high: valids and drive state clear, and the
// configuration registers return to their defaults.
// A stalled result holds in the result register; the input register keeps filling,
// and req_chan.ready drops only when both stages are full and rsp_chan.ready is low.
module obstacle_avoid_drive_fsm #(
   parameter int DIST_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   oad_req_if.sink     req_chan,
   oad_rsp_if.source   rsp_chan,
   oad_csr_if.sink     csr_chan
);

   logic                              req_valid_ff;
   logic [oad_pkg::KIND_WIDTH-1:0]    kind_ff;
   logic [DIST_WIDTH-1:0]             fl_ff, fr_ff, bl_ff, br_ff;
   logic [oad_pkg::MOTION_WIDTH-1:0]  forced_ff;
   logic                              wanted_ff;
   logic                              rsp_valid_ff;
   logic                              advance;
   logic                              req_take;
   oad_pkg::cfg_type                  cfg;
   oad_pkg::sense_type                sense;
   oad_pkg::rsp_type                  result;

   // The held item moves on when the result register is free or being emptied.
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   // Input register valid and result register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff   <= req_chan.kind;
         fl_ff     <= DIST_WIDTH'(req_chan.dist_front_left);
         fr_ff     <= DIST_WIDTH'(req_chan.dist_front_right);
         bl_ff     <= DIST_WIDTH'(req_chan.dist_back_left);
         br_ff     <= DIST_WIDTH'(req_chan.dist_back_right);
         forced_ff <= req_chan.forced_state;
         wanted_ff <= req_chan.wanted_mode;
      end
   end

   oad_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   oad_sense #(
      .DIST_WIDTH (DIST_WIDTH)
   ) u_sense (
      .dist_front_left  (fl_ff),
      .dist_front_right (fr_ff),
      .dist_back_left   (bl_ff),
      .dist_back_right  (br_ff),
      .cfg              (cfg),
      .sense            (sense)
   );

   oad_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .kind         (kind_ff),
      .forced_state (forced_ff),
      .wanted_mode  (wanted_ff),
      .sense        (sense),
      .cfg          (cfg),
      .result       (result)
   );

   // Result channel.
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.motion    = result.motion;
   assign rsp_chan.mode_now  = result.mode_now;
   assign rsp_chan.front_hit = result.front_hit;
   assign rsp_chan.rear_hit  = result.rear_hit;
   assign rsp_chan.left_hit  = result.left_hit;
   assign rsp_chan.right_hit = result.right_hit;

   // Obstacle flags come only from auto ticks, so the mode must read auto.
   a_hits_auto: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (result.front_hit || result.rear_hit ||
                       result.left_hit || result.right_hit)
      |-> (result.mode_now == oad_pkg::MODE_AUTO))
      else $error("obstacle flag reported outside auto mode");

   // A blocked front never leaves the car driving forward.
   a_front_not_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result.front_hit |-> (result.motion != oad_pkg::MOTION_FWD))
      else $error("forward motion with front blocked");

   // A blocked rear never leaves the car reversing.
   a_rear_not_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result.rear_hit |-> (result.motion != oad_pkg::MOTION_BACK))
      else $error("backward motion with rear blocked");

   // A held item that cannot move on is still held next cycle.
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff)
      else $error("input register item dropped");

endmodule

### sim/obstacle_avoid_drive_fsm_test.sv
module obstacle_avoid_drive_fsm_test;

   localparam int DIST_W     = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_SHOWN  = 10;

   // Codes above the last motion state, used to exercise the fallback to stop.
   localparam logic [oad_pkg::MOTION_WIDTH-1:0] BAD_STATE_LO = 3'd5;
   localparam logic [oad_pkg::MOTION_WIDTH-1:0] BAD_STATE_HI = 3'd7;

   // One input item as the request channel carries it.
   typedef struct packed {
      oad_pkg::kind_type                kind;
      logic [DIST_W-1:0]                front_left;
      logic [DIST_W-1:0]                front_right;
      logic [DIST_W-1:0]                back_left;
      logic [DIST_W-1:0]                back_right;
      logic [oad_pkg::MOTION_WIDTH-1:0] forced_state;
      logic                             wanted_mode;
   } tick_item_type;

   // One line of the directed stimulus, with a hand-written result where it is obvious.
   typedef struct packed {
      tick_item_type     item;
      logic              typed;
      oad_pkg::rsp_type  want;
   } dir_entry_type;

   logic clock;
   logic reset;

   oad_req_if #(.DIST_WIDTH(DIST_W)) req_bus ();
   oad_rsp_if rsp_bus ();
   oad_csr_if csr_bus ();

   obstacle_avoid_drive_fsm #(.DIST_WIDTH(DIST_W)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow copy of the controller: registers, motion state, mode and dwell timer.
   oad_pkg::cfg_type                cfg;
   oad_pkg::motion_type             road_state;
   logic                            road_mode;
   logic [oad_pkg::TIMER_WIDTH-1:0] dwell;

   oad_pkg::rsp_type due_reports[$];
   int      fail_count;
   int      items_sent;
   int      results_seen;
   int      settings_used;
   int      state_visits[0:4];
   int      idle_cycles;

   // Stimulus shaping: calm stretches have no idling, scenes keep obstacles in place.
   bit calm;
   bit req_up;
   bit scene_front;
   bit scene_rear;
   int scene_len;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic below_thr(input logic [DIST_W-1:0] d, input logic [15:0] thr);
      return (d != '0) && (d < thr);
   endfunction

   // Far distance of one side; a missing echo counts as very far.
   function automatic logic [DIST_W-1:0] far_side(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
      logic [DIST_W-1:0] x;
      logic [DIST_W-1:0] y;
      x = (a == '0) ? DIST_W'(oad_pkg::NO_ECHO_FAR) : a;
      y = (b == '0) ? DIST_W'(oad_pkg::NO_ECHO_FAR) : b;
      return (x > y) ? x : y;
   endfunction

   function automatic void bump_dwell();
      if (dwell != oad_pkg::TIMER_MAX) dwell = dwell + 1'b1;
   endfunction

   // Advances the shadow controller by one item and returns the report it must produce.
   function automatic oad_pkg::rsp_type next_motion_report(input tick_item_type it);
      logic             fb;
      logic             bb;
      logic             lb;
      logic             rb;
      oad_pkg::rsp_type r;
      fb = 1'b0;
      bb = 1'b0;
      lb = 1'b0;
      rb = 1'b0;
      case (it.kind)
         oad_pkg::KIND_TICK: begin
            if (road_mode == oad_pkg::MODE_AUTO) begin
               fb = below_thr(it.front_left, cfg.stop_limit) ||
                    below_thr(it.front_right, cfg.stop_limit);
               bb = below_thr(it.back_left, cfg.stop_limit) ||
                    below_thr(it.back_right, cfg.stop_limit);
               lb = below_thr(it.front_left, cfg.side_limit) ||
                    below_thr(it.back_left, cfg.side_limit);
               rb = below_thr(it.front_right, cfg.side_limit) ||
                    below_thr(it.back_right, cfg.side_limit);
               case (road_state)
                  oad_pkg::MOTION_FWD: begin
                     if (fb) begin
                        road_state = oad_pkg::MOTION_STOP;
                        dwell = '0;
                     end
                  end
                  oad_pkg::MOTION_STOP: begin
                     bump_dwell();
                     if (dwell > oad_pkg::STOP_DWELL) begin
                        if (fb && !bb) begin
                           road_state = oad_pkg::MOTION_BACK;
                           dwell = '0;
                        end else if (!fb) begin
                           road_state = oad_pkg::MOTION_FWD;
                           dwell = '0;
                        end
                     end
                  end
                  oad_pkg::MOTION_BACK: begin
                     bump_dwell();
                     if (dwell > cfg.backward_ticks) begin
                        if (far_side(it.front_right, it.back_right) >
                            far_side(it.front_left, it.back_left) && !rb)
                           road_state = oad_pkg::MOTION_RIGHT;
                        else if (!lb)
                           road_state = oad_pkg::MOTION_LEFT;
                        else if (!fb)
                           road_state = oad_pkg::MOTION_FWD;
                        else
                           road_state = oad_pkg::MOTION_STOP;
                        dwell = '0;
                     end
                     // A blocked rear always wins over the turn choice.
                     if (bb) begin
                        road_state = oad_pkg::MOTION_STOP;
                        dwell = '0;
                     end
                  end
                  oad_pkg::MOTION_LEFT, oad_pkg::MOTION_RIGHT: begin
                     bump_dwell();
                     if (dwell > cfg.turn_dwell) begin
                        road_state = fb ? oad_pkg::MOTION_STOP : oad_pkg::MOTION_FWD;
                        dwell = '0;
                     end
                  end
                  default: road_state = oad_pkg::MOTION_STOP;
               endcase
            end
         end
         oad_pkg::KIND_FORCE: begin
            road_state = (it.forced_state <= oad_pkg::MOTION_RIGHT) ?
                         oad_pkg::motion_type'(it.forced_state) : oad_pkg::MOTION_STOP;
            dwell = '0;
         end
         oad_pkg::KIND_MODE: begin
            if (it.wanted_mode != road_mode) begin
               road_mode = it.wanted_mode;
               road_state = oad_pkg::MOTION_STOP;
               dwell = '0;
            end
         end
         default: road_state = oad_pkg::MOTION_STOP;
      endcase
      state_visits[road_state]++;
      r.motion    = road_state;
      r.mode_now  = road_mode;
      r.front_hit = fb;
      r.rear_hit  = bb;
      r.left_hit  = lb;
      r.right_hit = rb;
      return r;
   endfunction

   function automatic dir_entry_type make_row(input oad_pkg::kind_type k,
                                              input logic [DIST_W-1:0] fl,
                                              input logic [DIST_W-1:0] fr,
                                              input logic [DIST_W-1:0] bl,
                                              input logic [DIST_W-1:0] br,
                                              input logic [oad_pkg::MOTION_WIDTH-1:0] fs,
                                              input logic wm, input logic typed,
                                              input oad_pkg::motion_type m,
                                              input logic md,
                                              input logic [3:0] hits);
      dir_entry_type e;
      e.item  = '{k, fl, fr, bl, br, fs, wm};
      e.typed = typed;
      e.want  = {m, md, hits};
      return e;
   endfunction

   // A reading mostly near the current thresholds; deliberately blocking only when allowed.
   function automatic logic [DIST_W-1:0] reading_for(input bit may_block);
      logic [15:0]       hi;
      logic [15:0]       thr;
      logic [16:0]       sum;
      logic [DIST_W-1:0] far_val;
      hi = (cfg.stop_limit > cfg.side_limit) ? cfg.stop_limit : cfg.side_limit;
      thr = $urandom_range(0, 1) ? cfg.stop_limit : cfg.side_limit;
      sum = 17'(hi) + 17'($urandom_range(1, 300));
      far_val = sum[16] ? '1 : sum[15:0];
      case ($urandom_range(0, 7))
         0: return '0;
         1: return DIST_W'($urandom);
         2: return hi;
         3: return far_val;
         default: begin
            if (may_block && thr > 1) begin
               case ($urandom_range(0, 3))
                  0: return thr - 1'b1;
                  1: return 1;
                  default: return DIST_W'($urandom_range(1, thr - 1));
               endcase
            end
            return far_val;
         end
      endcase
   endfunction

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_SHOWN) $display("ERROR: %s", msg);
   endtask

   // Presents one item, waits for its transfer and records the report it should cause.
   task automatic send_item(input tick_item_type it, input logic typed,
                            input oad_pkg::rsp_type typed_want);
      int               gap;
      oad_pkg::rsp_type want;
      gap = pick_gap();
      if (gap > 0) begin
         if (req_up) req_bus.valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.kind             <= it.kind;
      req_bus.dist_front_left  <= it.front_left;
      req_bus.dist_front_right <= it.front_right;
      req_bus.dist_back_left   <= it.back_left;
      req_bus.dist_back_right  <= it.back_right;
      req_bus.forced_state     <= it.forced_state;
      req_bus.wanted_mode      <= it.wanted_mode;
      req_up = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = next_motion_report(it);
      if (typed) want = typed_want;
      due_reports.push_back(want);
      items_sent++;
   endtask

   task automatic csr_write(input logic [oad_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [oad_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         oad_pkg::CSR_STOP_LIMIT:     cfg.stop_limit     = data;
         oad_pkg::CSR_SIDE_LIMIT:     cfg.side_limit     = data;
         oad_pkg::CSR_BACKWARD_TICKS: cfg.backward_ticks = data;
         oad_pkg::CSR_TURN_DWELL:     cfg.turn_dwell     = data;
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drains the block, then loads a new register setting plus a write to an unused index.
   task automatic reconfigure(input oad_pkg::cfg_type c);
      if (req_up) req_bus.valid <= 1'b0;
      req_up = 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(oad_pkg::CSR_STOP_LIMIT, c.stop_limit);
      csr_write(oad_pkg::CSR_SIDE_LIMIT, c.side_limit);
      csr_write(oad_pkg::CSR_BACKWARD_TICKS, c.backward_ticks);
      csr_write(oad_pkg::CSR_TURN_DWELL, c.turn_dwell);
      csr_write(oad_pkg::CSR_INDEX_WIDTH'($urandom_range(4, 255)),
                oad_pkg::CSR_DATA_WIDTH'($urandom));
      settings_used++;
   endtask

   // Mostly auto-mode ticks with obstacles that persist for a while, mixed with other kinds.
   task automatic run_random(input int quota);
      tick_item_type it;
      int            counted;
      int            pick;
      counted = 0;
      while (counted < quota) begin
         if ($urandom_range(0, 99) == 0) calm = !calm;
         pick = $urandom_range(0, 99);
         it.front_left   = DIST_W'($urandom);
         it.front_right  = DIST_W'($urandom);
         it.back_left    = DIST_W'($urandom);
         it.back_right   = DIST_W'($urandom);
         it.forced_state = oad_pkg::MOTION_WIDTH'($urandom_range(0, 7));
         it.wanted_mode  = 1'($urandom_range(0, 1));
         if (pick < 84) begin
            it.kind = oad_pkg::KIND_TICK;
            if (scene_len == 0) begin
               scene_front = 1'($urandom_range(0, 1));
               scene_rear  = ($urandom_range(0, 3) == 0);
               scene_len   = $urandom_range(1, 16);
            end
            scene_len--;
            if ($urandom_range(0, 19) != 0) begin
               it.front_left  = reading_for(scene_front);
               it.front_right = reading_for(scene_front);
               it.back_left   = reading_for(scene_rear);
               it.back_right  = reading_for(scene_rear);
            end
         end else if (pick < 90) begin
            it.kind = oad_pkg::KIND_FORCE;
         end else if (pick < 95) begin
            it.kind = oad_pkg::KIND_MODE;
            // Keep remote stretches short so most ticks reach the state machine.
            if (road_mode == oad_pkg::MODE_REMOTE)
               it.wanted_mode = ($urandom_range(0, 3) != 0) ? oad_pkg::MODE_AUTO
                                                            : oad_pkg::MODE_REMOTE;
         end else begin
            it.kind = oad_pkg::KIND_ESTOP;
         end
         counted++;
         send_item(it, 1'b0, '0);
      end
   endtask

   // Result receiver with random back-pressure.
   initial begin : rsp_pacer
      int run;
      int hold;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         run = $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Compare each result transfer with the oldest pending report.
   always @(posedge clock) begin : report_check
      oad_pkg::rsp_type got;
      oad_pkg::rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.motion, rsp_bus.mode_now, rsp_bus.front_hit, rsp_bus.rear_hit,
                rsp_bus.left_hit, rsp_bus.right_hit};
         results_seen++;
         if (due_reports.size() == 0) begin
            log_failure($sformatf("result with nothing pending: motion=%0d mode=%0b",
                                  got.motion, got.mode_now));
         end else begin
            want = due_reports.pop_front();
            if (got.motion !== want.motion || got.mode_now !== want.mode_now ||
                got.front_hit !== want.front_hit || got.rear_hit !== want.rear_hit ||
                got.left_hit !== want.left_hit || got.right_hit !== want.right_hit)
               log_failure({
                  $sformatf("result %0d: expected motion=%0d mode=%0b %s",
                            results_seen, want.motion, want.mode_now,
                            $sformatf("front=%b rear=%b left=%b right=%b,",
                                      want.front_hit, want.rear_hit,
                                      want.left_hit, want.right_hit)),
                  $sformatf(" got motion=%0d mode=%0b front=%b rear=%b left=%b right=%b",
                            got.motion, got.mode_now, got.front_hit,
                            got.rear_hit, got.left_hit, got.right_hit)});
         end
      end
   end

   // Watchdog: ends the run when no channel has a transfer for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer.", idle_cycles);
         $display("FAIL obstacle_avoid_drive_fsm");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      dir_entry_type    directed_rows[$];
      oad_pkg::cfg_type new_cfg;

      req_bus.valid            <= 1'b0;
      req_bus.kind             <= oad_pkg::KIND_TICK;
      req_bus.dist_front_left  <= '0;
      req_bus.dist_front_right <= '0;
      req_bus.dist_back_left   <= '0;
      req_bus.dist_back_right  <= '0;
      req_bus.forced_state     <= '0;
      req_bus.wanted_mode      <= oad_pkg::MODE_AUTO;
      csr_bus.valid            <= 1'b0;
      csr_bus.index            <= '0;
      csr_bus.data             <= '0;
      reset                    <= 1'b1;

      cfg = '{oad_pkg::STOP_LIMIT_RESET, oad_pkg::SIDE_LIMIT_RESET,
              oad_pkg::BACKWARD_TICKS_RESET, oad_pkg::TURN_DWELL_RESET};
      road_state = oad_pkg::MOTION_STOP;
      road_mode  = oad_pkg::MODE_AUTO;
      dwell      = '0;
      calm       = 1'b0;
      req_up     = 1'b0;
      scene_len  = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: no echo, maximum readings, thresholds, every kind, remote mode.
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0,
                                       1, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, '1, '1, '1, '1, 0, 0,
                                       1, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, 1, 0, 0, 0, 0, 0,
                                       1, oad_pkg::MOTION_BACK, oad_pkg::MODE_AUTO, 4'b1010));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, 0, 0, 0, 1, 0, 0,
                                       1, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0101));
      directed_rows.push_back(make_row(oad_pkg::KIND_FORCE, 16'h1234, 16'hFFFF, 0, 1,
                                       BAD_STATE_HI, 1,
                                       1, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_FORCE, 1, 1, 1, 1,
                                       oad_pkg::MOTION_FWD, 0,
                                       1, oad_pkg::MOTION_FWD, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, 0, 29, 0, 0, 0, 0,
                                       1, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b1000));
      directed_rows.push_back(make_row(oad_pkg::KIND_FORCE, 0, 0, 0, 0,
                                       oad_pkg::MOTION_BACK, 0,
                                       1, oad_pkg::MOTION_BACK, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, 30, 30, 30, 30, 0, 0,
                                       1, oad_pkg::MOTION_BACK, oad_pkg::MODE_AUTO, 4'b0000));
      // Emergency stop keeps the dwell count, so the second clear tick below moves on.
      directed_rows.push_back(make_row(oad_pkg::KIND_ESTOP, 5, 5, 5, 5, '1, 1,
                                       1, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, 100, 100, 100, 100, 0, 0,
                                       0, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, 100, 100, 100, 100, 0, 0,
                                       0, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_MODE, 0, 0, 0, 0, 0,
                                       oad_pkg::MODE_REMOTE, 1, oad_pkg::MOTION_STOP,
                                       oad_pkg::MODE_REMOTE, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, 1, 1, 1, 1, 0, 0,
                                       1, oad_pkg::MOTION_STOP, oad_pkg::MODE_REMOTE,
                                       4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_MODE, 0, 0, 0, 0, 0,
                                       oad_pkg::MODE_REMOTE, 1, oad_pkg::MOTION_STOP,
                                       oad_pkg::MODE_REMOTE, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_FORCE, 0, 0, 0, 0,
                                       oad_pkg::MOTION_LEFT, 0,
                                       1, oad_pkg::MOTION_LEFT, oad_pkg::MODE_REMOTE,
                                       4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_ESTOP, 0, 0, 0, 0, 0, 0,
                                       1, oad_pkg::MOTION_STOP, oad_pkg::MODE_REMOTE,
                                       4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_MODE, 0, 0, 0, 0, 0,
                                       oad_pkg::MODE_AUTO, 1, oad_pkg::MOTION_STOP,
                                       oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_FORCE, 0, 0, 0, 0,
                                       oad_pkg::MOTION_RIGHT, 0,
                                       0, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, 20, 20, 20, 20, 0, 0,
                                       0, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_FORCE, 0, 0, 0, 0, BAD_STATE_LO, 0,
                                       0, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_FORCE, 0, 0, 0, 0,
                                       oad_pkg::MOTION_BACK, 0,
                                       0, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      directed_rows.push_back(make_row(oad_pkg::KIND_TICK, '1, 0, 14, 40000, 0, 0,
                                       0, oad_pkg::MOTION_STOP, oad_pkg::MODE_AUTO, 4'b0000));
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      // Random part over several register settings, extremes included.
      settings_used = 1;
      run_random(215);
      for (int phase = 1; phase < 7; phase++) begin
         case (phase)
            1: new_cfg = '{16'd0, 16'd0, 16'd0, 16'd0};
            2: new_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            4: new_cfg = '{16'hFFFF, 16'd0, 16'd0, 16'd1};
            5: new_cfg = '{16'd0, 16'hFFFF, 16'd2, 16'd3};
            default: new_cfg = '{16'($urandom_range(20, 300)), 16'($urandom_range(5, 150)),
                                 16'($urandom_range(0, 12)), 16'($urandom_range(0, 12))};
         endcase
         reconfigure(new_cfg);
         run_random(215);
      end

      // Drain and allow time for any stray result to show up.
      if (req_up) req_bus.valid <= 1'b0;
      req_up = 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d items and %0d results over %0d register settings, %s",
               items_sent, results_seen, settings_used,
               "including remote mode, forced states and emergency stops.");
      $display("Predicted states: stop %0d, forward %0d, backward %0d, left %0d, right %0d.",
               state_visits[oad_pkg::MOTION_STOP], state_visits[oad_pkg::MOTION_FWD],
               state_visits[oad_pkg::MOTION_BACK], state_visits[oad_pkg::MOTION_LEFT],
               state_visits[oad_pkg::MOTION_RIGHT]);
      if (fail_count == 0 && due_reports.size() == 0) begin
         $display("PASS obstacle_avoid_drive_fsm");
      end else begin
         $display("%0d failures, %0d results still pending.", fail_count, due_reports.size());
         $display("FAIL obstacle_avoid_drive_fsm");
      end
      $finish;
   end

endmodule

### obstacle_avoid_drive_fsm.f
src/oad_pkg.sv
src/oad_req_if.sv
src/oad_rsp_if.sv
src/oad_csr_if.sv
src/oad_csr.sv
src/oad_sense.sv
src/oad_fsm.sv
src/obstacle_avoid_drive_fsm.sv
sim/obstacle_avoid_drive_fsm_test.sv
